// ----- rtl/rfb_pkg.sv -----
// Shared constants for the rotated framebuffer pixel writer.
package rfb_pkg;

    localparam int PANEL_WIDTH  = 960;
    localparam int PANEL_HEIGHT = 540;

    localparam int MAX_DIM  = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int COORD_W  = $clog2(MAX_DIM);

    localparam int MONO_STRIDE = (PANEL_WIDTH + 7) / 8;
    localparam int GRAY_STRIDE = (PANEL_WIDTH + 1) / 2;
    localparam int MONO_BYTES  = MONO_STRIDE * PANEL_HEIGHT;
    localparam int GRAY_BYTES  = GRAY_STRIDE * PANEL_HEIGHT;
    localparam int MONO_AW     = $clog2(MONO_BYTES);
    localparam int GRAY_AW     = $clog2(GRAY_BYTES);

    localparam int OUT_ADDR_W  = 18;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROTATION  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAY_MODE = 1'd1;

    localparam logic [1:0] ROT_NONE  = 2'd0;
    localparam logic [1:0] ROT_LEFT  = 2'd1;
    localparam logic [1:0] ROT_FLIP  = 2'd2;
    localparam logic [1:0] ROT_RIGHT = 2'd3;

    localparam logic PLANE_MONO = 1'b0;
    localparam logic PLANE_GRAY = 1'b1;

endpackage

// ----- rtl/rotated_framebuffer_pixel_write.sv -----
// Rotated framebuffer pixel writer: rotation, address, RMW of mono and gray planes.
//
// After reset the block runs a clearing pass over all GRAY_BYTES gray entries (259200 at
// the default 960x540 panel), filling the mono plane with 0x00 and the gray plane with
// 0xFF; s_tready stays low until it ends. From then on it takes one pixel word per
// cycle unless m_tready stalls it, and gives one result word per accepted word
// through the stage registers and the output register. The pipeline is coordinate
// mapping, address multiply, RAM read, then modify and write back; a write to the
// byte read in the cycle before is forwarded. A low m_tready while a result waits
// holds the whole pipeline, so throughput is set by m_tready, not the RAM port pair.
// The user must write configuration only while no word is in flight (not enforced).
module rotated_framebuffer_pixel_write
    import rfb_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // pos_x[15:0], pos_y[31:16], colour[39:32]

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // written[0], byte_address[18:1],
                                               // new_byte[26:19], zero[31:27]
    output logic [0:0]              m_tuser    // plane[0]
);

    // configuration
    logic [1:0] rotation_reg;
    logic       gray_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg  <= ROT_NONE;
            gray_mode_reg <= PLANE_MONO;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROTATION:  rotation_reg  <= cfg_wr_data[1:0];
                REG_GRAY_MODE: gray_mode_reg <= cfg_wr_data[0];
            endcase
        end
    end

    // clearing pass
    logic               clr_busy_reg;
    logic [GRAY_AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == GRAY_AW'(GRAY_BYTES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // pipeline control
    logic adv;
    logic s_accept;
    logic m_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv && !clr_busy_reg;
    assign s_accept = s_tvalid && s_tready;

    // stage 1: bounds and rotation
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic               sideways;
    logic [14:0]        lw;
    logic [14:0]        lh;
    logic               in_area;
    logic [COORD_W-1:0] xc;
    logic [COORD_W-1:0] yc;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;

    always_comb begin
        in_x     = signed'(s_tdata[15:0]);
        in_y     = signed'(s_tdata[31:16]);
        sideways = (rotation_reg == ROT_LEFT) || (rotation_reg == ROT_RIGHT);
        lw       = sideways ? 15'(PANEL_HEIGHT) : 15'(PANEL_WIDTH);
        lh       = sideways ? 15'(PANEL_WIDTH)  : 15'(PANEL_HEIGHT);
        in_area  = !in_x[15] && !in_y[15] && (in_x[14:0] < lw) && (in_y[14:0] < lh);
        xc       = in_x[COORD_W-1:0];
        yc       = in_y[COORD_W-1:0];
        unique case (rotation_reg)
            ROT_LEFT: begin
                px = COORD_W'(PANEL_WIDTH - 1) - yc;
                py = xc;
            end
            ROT_FLIP: begin
                px = COORD_W'(PANEL_WIDTH - 1) - xc;
                py = COORD_W'(PANEL_HEIGHT - 1) - yc;
            end
            ROT_RIGHT: begin
                px = yc;
                py = COORD_W'(PANEL_HEIGHT - 1) - xc;
            end
            ROT_NONE: begin
                px = xc;
                py = yc;
            end
        endcase
    end

    logic               s1_valid_reg;
    logic               s1_inside_reg;
    logic               s1_plane_reg;
    logic [COORD_W-1:0] s1_px_reg;
    logic [COORD_W-1:0] s1_py_reg;
    logic [7:0]         s1_colour_reg;

    // stage 2: byte address
    logic [GRAY_AW-1:0] s2_addr_next;

    always_comb begin
        if (s1_plane_reg == PLANE_GRAY) begin
            s2_addr_next = GRAY_AW'(s1_py_reg) * GRAY_AW'(GRAY_STRIDE)
                         + GRAY_AW'(s1_px_reg >> 1);
        end else begin
            s2_addr_next = GRAY_AW'(s1_py_reg) * GRAY_AW'(MONO_STRIDE)
                         + GRAY_AW'(s1_px_reg >> 3);
        end
    end

    logic               s2_valid_reg;
    logic               s2_inside_reg;
    logic               s2_plane_reg;
    logic [GRAY_AW-1:0] s2_addr_reg;
    logic [2:0]         s2_sel_reg;
    logic [7:0]         s2_colour_reg;

    // stage 3: modify and write back
    logic               s3_valid_reg;
    logic               s3_inside_reg;
    logic               s3_plane_reg;
    logic [GRAY_AW-1:0] s3_addr_reg;
    logic [2:0]         s3_sel_reg;
    logic [7:0]         s3_colour_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_inside_reg <= in_area;
            s1_plane_reg  <= gray_mode_reg;
            s1_px_reg     <= px;
            s1_py_reg     <= py;
            s1_colour_reg <= s_tdata[39:32];

            s2_inside_reg <= s1_inside_reg;
            s2_plane_reg  <= s1_plane_reg;
            s2_addr_reg   <= s2_addr_next;
            s2_sel_reg    <= s1_px_reg[2:0];
            s2_colour_reg <= s1_colour_reg;

            s3_inside_reg <= s2_inside_reg;
            s3_plane_reg  <= s2_plane_reg;
            s3_addr_reg   <= s2_addr_reg;
            s3_sel_reg    <= s2_sel_reg;
            s3_colour_reg <= s2_colour_reg;
        end
    end

    // memories
    logic [7:0] mono_mem [MONO_BYTES];
    logic [7:0] gray_mem [GRAY_BYTES];
    logic [7:0] mono_rd_reg;
    logic [7:0] gray_rd_reg;

    logic               s3_write;
    logic               mono_we;
    logic               gray_we;
    logic [MONO_AW-1:0] mono_waddr;
    logic [GRAY_AW-1:0] gray_waddr;
    logic [7:0]         mono_wdata;
    logic [7:0]         gray_wdata;

    // forwarding of the write made at the edge of the previous read
    logic               fwd_valid_reg;
    logic               fwd_plane_reg;
    logic [GRAY_AW-1:0] fwd_addr_reg;
    logic [7:0]         fwd_data_reg;

    logic       fwd_hit;
    logic [7:0] base;
    logic [7:0] mask;
    logic [7:0] new_byte;

    always_comb begin
        fwd_hit = fwd_valid_reg && (fwd_plane_reg == s3_plane_reg)
                  && (fwd_addr_reg == s3_addr_reg);
        if (fwd_hit) begin
            base = fwd_data_reg;
        end else if (s3_plane_reg == PLANE_GRAY) begin
            base = gray_rd_reg;
        end else begin
            base = mono_rd_reg;
        end
        mask = 8'd1 << s3_sel_reg;
        if (s3_plane_reg == PLANE_GRAY) begin
            if (s3_sel_reg[0]) begin
                new_byte = {base[7:4], 1'b0, s3_colour_reg[2:0]};
            end else begin
                new_byte = {1'b0, s3_colour_reg[2:0], base[3:0]};
            end
        end else begin
            new_byte = (base & ~mask) | ((s3_colour_reg != 8'd0) ? mask : 8'd0);
        end
    end

    assign s3_write   = adv && s3_valid_reg && s3_inside_reg;
    assign mono_we    = clr_busy_reg ? (clr_cnt_reg < GRAY_AW'(MONO_BYTES))
                                     : (s3_write && (s3_plane_reg == PLANE_MONO));
    assign gray_we    = clr_busy_reg || (s3_write && (s3_plane_reg == PLANE_GRAY));
    assign mono_waddr = clr_busy_reg ? clr_cnt_reg[MONO_AW-1:0] : s3_addr_reg[MONO_AW-1:0];
    assign gray_waddr = clr_busy_reg ? clr_cnt_reg : s3_addr_reg;
    assign mono_wdata = clr_busy_reg ? 8'h00 : new_byte;
    assign gray_wdata = clr_busy_reg ? 8'hFF : new_byte;

    always_ff @(posedge aclk) begin
        if (mono_we) begin
            mono_mem[mono_waddr] <= mono_wdata;
        end
        if (adv && (s2_plane_reg == PLANE_MONO)) begin
            mono_rd_reg <= mono_mem[s2_addr_reg[MONO_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (gray_we) begin
            gray_mem[gray_waddr] <= gray_wdata;
        end
        if (adv && (s2_plane_reg == PLANE_GRAY)) begin
            gray_rd_reg <= gray_mem[s2_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (adv) begin
            fwd_valid_reg <= s3_valid_reg && s3_inside_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fwd_plane_reg <= s3_plane_reg;
            fwd_addr_reg  <= s3_addr_reg;
            fwd_data_reg  <= new_byte;
        end
    end

    // output register
    logic                  m_written_reg;
    logic                  m_plane_reg;
    logic [OUT_ADDR_W-1:0] m_addr_reg;
    logic [7:0]            m_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_written_reg <= s3_inside_reg;
            m_plane_reg   <= s3_plane_reg;
            m_addr_reg    <= s3_inside_reg ? OUT_ADDR_W'(s3_addr_reg) : '0;
            m_byte_reg    <= s3_inside_reg ? new_byte : 8'd0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_byte_reg, m_addr_reg, m_written_reg};
    assign m_tuser  = m_plane_reg;

    // assertions
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_tready)
        else $error("word accepted during clearing pass");

    a_clear_ends_at_last_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_busy_reg) |-> $past(clr_cnt_reg) == GRAY_AW'(GRAY_BYTES - 1))
        else $error("clearing pass ended early");

    a_dropped_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_written_reg) |-> (m_addr_reg == '0) && (m_byte_reg == 8'd0))
        else $error("dropped point carries address or data");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg, fwd_valid_reg}))
        else $error("pipeline moved during stall");

    a_no_pipe_write_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !(s3_valid_reg || s2_valid_reg || s1_valid_reg))
        else $error("pipeline active during clearing pass");

endmodule
